// File: rtl/dhks_pkg.sv
// dhks_pkg: shared types and constants for the double-hashed key set
// no dependencies; imported by dhks_csub, dhks_mem and double_hash_key_set
`timescale 1ns / 1ps

package dhks_pkg;

   // fixed field widths of the request and response words
   localparam int CMD_WIDTH   = 2;
   localparam int KEY_WIDTH   = 32;
   localparam int STAT_WIDTH  = 2;
   localparam int SLOT_WIDTH  = 9;
   localparam int COUNT_WIDTH = 9;

   // request commands
   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   // response status codes
   typedef enum logic [STAT_WIDTH-1:0] {
      STS_OK       = 2'd0,
      STS_FULL     = 2'd1,
      STS_MISSING  = 2'd2,
      STS_RESERVED = 2'd3
   } status_type;

   // per-slot tag kept beside each stored key
   typedef enum logic [1:0] {
      TAG_FREE = 2'd0,
      TAG_LIVE = 2'd1,
      TAG_TOMB = 2'd2
   } tag_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_QD,
      ST_FIX,
      ST_BACK,
      ST_PROBE_RD,
      ST_PROBE_CHK,
      ST_RESP
   } state_type;

endpackage

// File: rtl/double_hash_key_set.sv
// double_hash_key_set: open-addressing key set with double hashing and tombstones
// depends on dhks_pkg, dhks_csub and dhks_mem
`timescale 1ns / 1ps

// Usage
//   Request word (req_command, req_key) is taken when req_valid is high and
//   req_stall low. req_stall is high whenever the sequencer is busy, so one
//   word is worked on at a time. Each word gives exactly one response word
//   (rsp_status, rsp_slot, rsp_live_count, rsp_peak_count) on rsp_valid,
//   held steady while rsp_stall is high; a new request is taken while a
//   finished response still waits.
//   Steps per word: for insert or remove, each modulo (TABLE_SIZE, then
//   TABLE_SIZE-2) is a reciprocal multiply, a quotient times divisor product
//   and one correction on the shared compare-subtract unit, then the ST_BACK
//   state forms the backward step and each probe is a table read followed by
//   a check, before the result goes to ST_RESP. Reserved keys, a full count
//   and the unused command go from ST_IDLE straight to ST_RESP. Clear sweeps
//   the table one slot per cycle before its response.
//   Reset: a clearing pass marks every slot free, with req_stall high;
//   counts and peak start at zero.
//   A stalled response keeps the next finished word in the sequencer, with
//   req_stall high, until the response register is taken.

module double_hash_key_set #(
   parameter int TABLE_SIZE = 503,
   parameter int KEY_BITS   = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [dhks_pkg::CMD_WIDTH-1:0]   req_command,
   input  logic [dhks_pkg::KEY_WIDTH-1:0]   req_key,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [dhks_pkg::STAT_WIDTH-1:0]  rsp_status,
   output logic [dhks_pkg::SLOT_WIDTH-1:0]  rsp_slot,
   output logic [dhks_pkg::COUNT_WIDTH-1:0] rsp_live_count,
   output logic [dhks_pkg::COUNT_WIDTH-1:0] rsp_peak_count
);
   import dhks_pkg::*;

   localparam int KW = (KEY_BITS < KEY_WIDTH) ? KEY_BITS : KEY_WIDTH;
   localparam int IW = $clog2(TABLE_SIZE);
   localparam int CW = IW + 1;
   localparam int NW = $clog2(TABLE_SIZE + 1);
   localparam int MW = KW + 2;
   localparam int PW = 2 * KW;
   localparam int XW = KW + CW;

   // reciprocal for divisor d with 2^(L-1) < d <= 2^L, shift KW - 1 + L:
   // the quotient estimate is exact or one low
   localparam int SH_SIZE = KW - 1 + $clog2(TABLE_SIZE);
   localparam int SH_STEP = KW - 1 + $clog2(TABLE_SIZE - 2);
   localparam logic [KW-1:0] RCP_SIZE = KW'((64'd1 << SH_SIZE) / TABLE_SIZE);
   localparam logic [KW-1:0] RCP_STEP = KW'((64'd1 << SH_STEP) / (TABLE_SIZE - 2));

   localparam logic [IW-1:0] LAST_IDX  = IW'(TABLE_SIZE - 1);
   localparam logic [CW-1:0] SIZE_OP   = CW'(TABLE_SIZE);
   localparam logic [CW-1:0] STEP_MOD  = CW'(TABLE_SIZE - 2);
   localparam logic [NW-1:0] SIZE_CNT  = NW'(TABLE_SIZE);
   localparam logic [NW-1:0] LAST_PRB  = NW'(TABLE_SIZE - 1);

   // sequencer and work registers
   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [KW-1:0]    key_ff, key_in;
   logic [PW-1:0]    prod_ff, prod_in;
   logic [XW-1:0]    qd_ff, qd_in;
   logic             pass_ff, pass_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [IW-1:0]    nidx_ff, nidx_in;
   logic [IW-1:0]    step_ff, step_in;
   logic [IW-1:0]    back_ff, back_in;
   logic [NW-1:0]    probe_ff, probe_in;
   logic [NW-1:0]    count_ff, count_in;
   logic [NW-1:0]    peak_ff, peak_in;
   logic             clr_rsp_ff, clr_rsp_in;
   status_type       res_status_ff, res_status_in;
   logic [IW-1:0]    res_slot_ff, res_slot_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_load;
   status_type             rsp_status_ff;
   logic [SLOT_WIDTH-1:0]  rsp_slot_ff;
   logic [COUNT_WIDTH-1:0] rsp_live_ff;
   logic [COUNT_WIDTH-1:0] rsp_peak_ff;

   // shared unit and memory hookup
   logic [CW-1:0] op_a, op_b, op_y;
   logic          wr_en, rd_en;
   logic [IW-1:0] wr_addr;
   logic [MW-1:0] wr_data, rd_data;
   tag_type       rd_tag;
   logic [KW-1:0] rd_key;
   logic [NW-1:0] cnt_inc;
   logic          req_accept;

   // modulo datapath
   logic [KW-1:0] rcp_sel;
   logic [CW-1:0] div_sel;
   logic [KW-1:0] quo;
   logic [PW-1:0] mul_y;
   logic [XW-1:0] qd_y;
   logic [XW-1:0] rem_wide;

   dhks_csub #(.W(CW)) u_csub (
      .a (op_a),
      .b (op_b),
      .y (op_y)
   );

   dhks_mem #(.DEPTH(TABLE_SIZE), .WIDTH(MW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rd_tag     = tag_type'(rd_data[MW-1:KW]);
   assign rd_key     = rd_data[KW-1:0];
   assign cnt_inc    = count_ff + NW'(1);

   // first pass reduces by the table size, second pass by size minus two
   assign rcp_sel  = pass_ff ? RCP_STEP : RCP_SIZE;
   assign div_sel  = pass_ff ? STEP_MOD : SIZE_OP;
   assign quo      = pass_ff ? KW'(prod_ff >> SH_STEP) : KW'(prod_ff >> SH_SIZE);
   assign mul_y    = PW'(key_ff) * PW'(rcp_sel);
   assign qd_y     = XW'(quo) * XW'(div_sel);
   assign rem_wide = XW'(key_ff) - qd_ff;

   // operand select for the shared compare-subtract unit
   always_comb begin
      case (state_ff)
         ST_FIX: begin
            op_a = rem_wide[CW-1:0];
            op_b = div_sel;
         end
         ST_BACK: begin
            op_a = SIZE_OP;
            op_b = {1'b0, step_ff};
         end
         ST_PROBE_RD: begin
            op_a = {1'b0, idx_ff} + {1'b0, back_ff};
            op_b = SIZE_OP;
         end
         default: begin
            op_a = '0;
            op_b = SIZE_OP;
         end
      endcase
   end

   // next state and datapath control
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      prod_in       = prod_ff;
      qd_in         = qd_ff;
      pass_in       = pass_ff;
      idx_in        = idx_ff;
      nidx_in       = nidx_ff;
      step_in       = step_ff;
      back_in       = back_ff;
      probe_in      = probe_ff;
      count_in      = count_ff;
      peak_in       = peak_ff;
      clr_rsp_in    = clr_rsp_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = {TAG_FREE, {KW{1'b0}}};
      rd_en         = 1'b0;
      rsp_load      = 1'b0;
      case (state_ff)
         // sweep every slot to free
         ST_CLEAR: begin
            wr_en  = 1'b1;
            idx_in = idx_ff + IW'(1);
            if (idx_ff == LAST_IDX) begin
               idx_in        = '0;
               res_status_in = STS_OK;
               res_slot_in   = '0;
               state_in      = clr_rsp_ff ? ST_RESP : ST_IDLE;
            end
         end
         // take a request word and sort out the quick cases
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in        = cmd_type'(req_command);
               key_in        = req_key[KW-1:0];
               pass_in       = 1'b0;
               res_status_in = STS_OK;
               res_slot_in   = '0;
               state_in      = ST_RESP;
               case (cmd_type'(req_command))
                  CMD_INSERT, CMD_REMOVE: begin
                     if (req_key[KW-1:1] == '0) begin
                        res_status_in = STS_RESERVED;
                     end else if (cmd_type'(req_command) == CMD_INSERT &&
                                  count_ff >= SIZE_CNT) begin
                        res_status_in = STS_FULL;
                     end else begin
                        state_in = ST_MUL;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in   = '0;
                     idx_in     = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         // key times reciprocal
         ST_MUL: begin
            prod_in  = mul_y;
            state_in = ST_QD;
         end
         // quotient estimate times divisor
         ST_QD: begin
            qd_in    = qd_y;
            state_in = ST_FIX;
         end
         // remainder below twice the divisor, one correction on the shared unit
         ST_FIX: begin
            if (!pass_ff) begin
               idx_in   = op_y[IW-1:0];
               pass_in  = 1'b1;
               state_in = ST_MUL;
            end else begin
               step_in  = (op_y[IW-1:0] == '0) ? IW'(1) : op_y[IW-1:0];
               state_in = ST_BACK;
            end
         end
         // backward step expressed as a forward add of size minus step
         ST_BACK: begin
            back_in  = op_y[IW-1:0];
            probe_in = '0;
            state_in = ST_PROBE_RD;
         end
         // read the slot, form the next probe index meanwhile
         ST_PROBE_RD: begin
            rd_en    = 1'b1;
            nidx_in  = op_y[IW-1:0];
            state_in = ST_PROBE_CHK;
         end
         // check the slot just read
         ST_PROBE_CHK: begin
            state_in = ST_PROBE_RD;
            idx_in   = nidx_ff;
            probe_in = probe_ff + NW'(1);
            if (cmd_ff == CMD_INSERT) begin
               if (rd_tag != TAG_LIVE) begin
                  wr_en         = 1'b1;
                  wr_data       = {TAG_LIVE, key_ff};
                  count_in      = cnt_inc;
                  peak_in       = (cnt_inc > peak_ff) ? cnt_inc : peak_ff;
                  res_status_in = STS_OK;
                  res_slot_in   = idx_ff;
                  idx_in        = idx_ff;
                  state_in      = ST_RESP;
               end else if (probe_ff == LAST_PRB) begin
                  res_status_in = STS_FULL;
                  res_slot_in   = '0;
                  state_in      = ST_RESP;
               end
            end else begin
               if (rd_tag == TAG_LIVE && rd_key == key_ff) begin
                  wr_en         = 1'b1;
                  wr_data       = {TAG_TOMB, rd_key};
                  count_in      = (count_ff != '0) ? count_ff - NW'(1) : count_ff;
                  res_status_in = STS_OK;
                  res_slot_in   = idx_ff;
                  idx_in        = idx_ff;
                  state_in      = ST_RESP;
               end else if (rd_tag == TAG_FREE || probe_ff == LAST_PRB) begin
                  res_status_in = STS_MISSING;
                  res_slot_in   = '0;
                  state_in      = ST_RESP;
               end
            end
         end
         // hand the result to the response register once it is free
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               idx_in   = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid: set on load, dropped when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         count_ff     <= '0;
         peak_ff      <= '0;
         pass_ff      <= 1'b0;
         probe_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         clr_rsp_ff   <= clr_rsp_in;
         count_ff     <= count_in;
         peak_ff      <= peak_in;
         pass_ff      <= pass_in;
         probe_ff     <= probe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      prod_ff       <= prod_in;
      qd_ff         <= qd_in;
      nidx_ff       <= nidx_in;
      step_ff       <= step_in;
      back_ff       <= back_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= SLOT_WIDTH'(res_slot_ff);
         rsp_live_ff   <= COUNT_WIDTH'(count_ff);
         rsp_peak_ff   <= COUNT_WIDTH'(peak_ff);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_live_count = rsp_live_ff;
   assign rsp_peak_count = rsp_peak_ff;

   // live count bounded by the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SIZE_CNT)
      else $error("live count above table size");

   // peak never below the live count
   a_peak_ge_count: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= count_ff)
      else $error("peak below live count");

   // a failed result never carries a slot
   a_fail_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && res_status_ff != STS_OK) |-> res_slot_ff == '0)
      else $error("non-ok result with nonzero slot");

   // clear empties the count at once
   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_command == CMD_CLEAR) |=> count_ff == '0)
      else $error("clear left a nonzero count");

endmodule

// File: rtl/dhks_csub.sv
// dhks_csub: shared compare-and-subtract unit, y = (a >= b) ? a - b : a
// depends on dhks_pkg; used for modulo reduction and probe index stepping
`timescale 1ns / 1ps

module dhks_csub #(
   parameter int W = 10
) (
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   output logic [W-1:0] y
);
   import dhks_pkg::*;

   logic [W:0] diff;

   // one subtract, borrow picks the result
   always_comb begin
      diff = {1'b0, a} - {1'b0, b};
      y    = diff[W] ? a : diff[W-1:0];
   end

endmodule

// File: rtl/dhks_mem.sv
// dhks_mem: single-port-write, single-port-read table with registered read data
// depends on dhks_pkg; holds tag and key for each slot
`timescale 1ns / 1ps

module dhks_mem #(
   parameter int DEPTH = 503,
   parameter int WIDTH = 34
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   import dhks_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
